>>> rtl/ess_pkg.sv
// Shared types, register reset values and status codes for the endstop sweep
// stepper controller. No dependencies; imported by every module of the block.
package ess_pkg;

    localparam int TIMER_WIDTH_DEF = 20;
    localparam int CNT_W           = 20;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    localparam logic [2:0] REG_STEP_HALF   = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd1;
    localparam logic [2:0] REG_BACKOFF     = 3'd2;
    localparam logic [2:0] REG_MAX_TRAVEL  = 3'd3;
    localparam logic [2:0] REG_TRIP_TOTAL  = 3'd4;
    localparam logic [2:0] REG_PAUSE_RIGHT = 3'd5;
    localparam logic [2:0] REG_PAUSE_LEFT  = 3'd6;

    localparam logic [15:0] RST_STEP_HALF   = 16'd150;
    localparam logic [19:0] RST_DEBOUNCE    = 20'd10000;
    localparam logic [15:0] RST_BACKOFF     = 16'd100;
    localparam logic [19:0] RST_MAX_TRAVEL  = 20'd100000;
    localparam logic [7:0]  RST_TRIP_TOTAL  = 8'd5;
    localparam logic [19:0] RST_PAUSE_RIGHT = 20'd200000;
    localparam logic [19:0] RST_PAUSE_LEFT  = 20'd400000;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RUNNING = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_ERR_R   = 3'd3;
    localparam logic [2:0] ST_ERR_L   = 3'd4;

    typedef struct packed {
        logic [15:0] step_half_ticks;
        logic [19:0] debounce_ticks;
        logic [15:0] retreat_steps;
        logic [19:0] travel_limit;
        logic [7:0]  trip_total;
        logic [19:0] pause_after_right_ticks;
        logic [19:0] pause_after_left_ticks;
    } t_cfg;

    typedef struct packed {
        logic start_req;
        logic left_endstop_n;
        logic right_endstop_n;
    } t_tick;

    typedef struct packed {
        logic       step_out;
        logic       dir_out;
        logic [2:0] status;
        logic [7:0] trip_number;
    } t_result;

endpackage

>>> rtl/endstop_sweep_stepper_controller_top.sv
// Endstop sweep stepper controller, top level: handshake, input and result stages.
// Depends on ess_pkg, ess_cfg_regs and ess_seq_core.
//
// Each input transfer is one time-base tick carrying the start request and the two
// active-low endstop levels; each produces exactly one result transfer with the step
// and direction lines, the status code and the current round trip number, showing the
// state after that tick. A tick is captured in an input register; the sequencer
// then updates its state and the result register once the result register is free
// or being taken, and the result waits there until taken. One tick is accepted
// every clock cycle while the result side keeps up. The user must write registers
// over the APB-style port only while no tick is in flight; the block itself does
// not enforce this.
module endstop_sweep_stepper_controller_top #(
    parameter int TIMER_WIDTH = ess_pkg::TIMER_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ess_pkg::ADDR_W-1:0] paddr,
    input  logic [ess_pkg::DATA_W-1:0] pwdata,
    output logic [ess_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_start_req,
    input  logic                       i_left_endstop_n,
    input  logic                       i_right_endstop_n,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_step_out,
    output logic                       o_dir_out,
    output logic [2:0]                 o_status,
    output logic [7:0]                 o_trip_number
);
    import ess_pkg::*;

    t_cfg    cfg;
    t_tick   r_tick;
    t_result result;
    logic    r_s1_valid;
    logic    r_out_valid;
    logic    adv;
    logic    in_xfer;

    assign adv        = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    ess_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_tick.start_req       <= i_start_req;
            r_tick.left_endstop_n  <= i_left_endstop_n;
            r_tick.right_endstop_n <= i_right_endstop_n;
        end
    end

    ess_seq_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_cfg    (cfg),
        .i_tick   (r_tick),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_out    = result.step_out;
    assign o_dir_out     = result.dir_out;
    assign o_status      = result.status;
    assign o_trip_number = result.trip_number;

endmodule

>>> rtl/ess_cfg_regs.sv
// APB-style configuration register file for the sweep controller.
// Depends on ess_pkg for register indexes, reset values and the t_cfg struct.
module ess_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ess_pkg::ADDR_W-1:0] paddr,
    input  logic [ess_pkg::DATA_W-1:0] pwdata,
    output logic [ess_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ess_pkg::t_cfg              o_cfg
);
    import ess_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_half_ticks         <= RST_STEP_HALF;
            r_cfg.debounce_ticks          <= RST_DEBOUNCE;
            r_cfg.retreat_steps           <= RST_BACKOFF;
            r_cfg.travel_limit            <= RST_MAX_TRAVEL;
            r_cfg.trip_total              <= RST_TRIP_TOTAL;
            r_cfg.pause_after_right_ticks <= RST_PAUSE_RIGHT;
            r_cfg.pause_after_left_ticks  <= RST_PAUSE_LEFT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_STEP_HALF:   r_cfg.step_half_ticks         <= pwdata[15:0];
                REG_DEBOUNCE:    r_cfg.debounce_ticks          <= pwdata[19:0];
                REG_BACKOFF:     r_cfg.retreat_steps           <= pwdata[15:0];
                REG_MAX_TRAVEL:  r_cfg.travel_limit            <= pwdata[19:0];
                REG_TRIP_TOTAL:  r_cfg.trip_total              <= pwdata[7:0];
                REG_PAUSE_RIGHT: r_cfg.pause_after_right_ticks <= pwdata[19:0];
                REG_PAUSE_LEFT:  r_cfg.pause_after_left_ticks  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STEP_HALF:   prdata = {16'd0, r_cfg.step_half_ticks};
            REG_DEBOUNCE:    prdata = {12'd0, r_cfg.debounce_ticks};
            REG_BACKOFF:     prdata = {16'd0, r_cfg.retreat_steps};
            REG_MAX_TRAVEL:  prdata = {12'd0, r_cfg.travel_limit};
            REG_TRIP_TOTAL:  prdata = {24'd0, r_cfg.trip_total};
            REG_PAUSE_RIGHT: prdata = {12'd0, r_cfg.pause_after_right_ticks};
            REG_PAUSE_LEFT:  prdata = {12'd0, r_cfg.pause_after_left_ticks};
            default:         prdata = '0;
        endcase
    end

endmodule

>>> rtl/ess_seq_core.sv
// Sweep sequencer: phase state, step and tick counters, and the result register.
// Depends on ess_pkg for t_cfg, t_tick, t_result and status codes.
module ess_seq_core #(
    parameter int TIMER_WIDTH = ess_pkg::TIMER_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  ess_pkg::t_cfg    i_cfg,
    input  ess_pkg::t_tick   i_tick,
    output ess_pkg::t_result o_result
);
    import ess_pkg::*;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_RL_CHK     = 4'd1;
    localparam logic [3:0] PH_RL_DEB     = 4'd2;
    localparam logic [3:0] PH_RL_MOVE    = 4'd3;
    localparam logic [3:0] PH_RR_CHK     = 4'd4;
    localparam logic [3:0] PH_RR_DEB     = 4'd5;
    localparam logic [3:0] PH_RR_MOVE    = 4'd6;
    localparam logic [3:0] PH_SEEK_CHK   = 4'd7;
    localparam logic [3:0] PH_SEEK_DEB   = 4'd8;
    localparam logic [3:0] PH_SEEK_PULSE = 4'd9;
    localparam logic [3:0] PH_BACKOFF    = 4'd10;
    localparam logic [3:0] PH_PAUSE      = 4'd11;
    localparam logic [3:0] PH_DONE       = 4'd12;
    localparam logic [3:0] PH_ERR_R      = 4'd13;
    localparam logic [3:0] PH_ERR_L      = 4'd14;
    localparam logic [3:0] PH_UNUSED     = 4'd15;

    localparam logic [32:0]            T_FULL = (33'd1 << TIMER_WIDTH) - 33'd1;
    localparam logic [TIMER_WIDTH-1:0] T_ONE  = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [CNT_W-1:0]       C_ONE  = {{(CNT_W-1){1'b0}}, 1'b1};

    function automatic logic [TIMER_WIDTH-1:0] tload(input logic [31:0] v);
        if ({1'b0, v} > T_FULL) begin
            return T_FULL[TIMER_WIDTH-1:0];
        end
        return v[TIMER_WIDTH-1:0];
    endfunction

    logic [3:0]             r_phase, n_phase;
    logic [CNT_W-1:0]       r_step_count, n_step_count;
    logic [TIMER_WIDTH-1:0] r_tick_timer, n_tick_timer;
    logic [7:0]             r_trip_count, n_trip_count;
    logic                   r_pulse_level, n_pulse_level;
    logic                   r_direction, n_direction;
    t_result                r_result, n_result;

    logic [15:0]            half;
    logic [TIMER_WIDTH-1:0] half_load, deb_load;
    logic [TIMER_WIDTH-1:0] adv_timer;
    logic                   adv_pulse, adv_done;
    logic                   pulse_idle, move_done;
    logic                   left_low, right_low, target_low;
    logic [CNT_W-1:0]       backoff_x5;

    assign half       = (i_cfg.step_half_ticks == 16'd0) ? 16'd1 : i_cfg.step_half_ticks;
    assign half_load  = tload({16'd0, half});
    assign deb_load   = tload({12'd0, i_cfg.debounce_ticks});
    assign left_low   = ~i_tick.left_endstop_n;
    assign right_low  = ~i_tick.right_endstop_n;
    assign target_low = r_direction ? right_low : left_low;
    assign backoff_x5 = {2'd0, i_cfg.retreat_steps, 2'd0} + {4'd0, i_cfg.retreat_steps};
    assign pulse_idle = ~r_pulse_level && (r_tick_timer == '0);
    assign move_done  = pulse_idle && (r_step_count == '0);

    always_comb begin
        adv_done  = 1'b0;
        adv_pulse = r_pulse_level;
        adv_timer = r_tick_timer;
        if (r_tick_timer > T_ONE) begin
            adv_timer = r_tick_timer - T_ONE;
        end else if (r_pulse_level) begin
            adv_pulse = 1'b0;
            adv_timer = half_load;
        end else begin
            adv_timer = '0;
            adv_done  = 1'b1;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_step_count  = r_step_count;
        n_tick_timer  = r_tick_timer;
        n_trip_count  = r_trip_count;
        n_pulse_level = r_pulse_level;
        n_direction   = r_direction;

        case (r_phase)
            PH_RL_CHK: begin
                if (left_low) begin
                    n_tick_timer = deb_load;
                    n_phase      = PH_RL_DEB;
                end else begin
                    n_phase = PH_RR_CHK;
                end
            end
            PH_RL_DEB: begin
                if (r_tick_timer != '0) begin
                    n_tick_timer = r_tick_timer - T_ONE;
                end else if (left_low) begin
                    n_direction  = 1'b1;
                    n_step_count = backoff_x5;
                    n_phase      = PH_RL_MOVE;
                end else begin
                    n_phase = PH_RR_CHK;
                end
            end
            PH_RL_MOVE, PH_RR_MOVE, PH_BACKOFF: begin
                if (move_done && r_phase == PH_RL_MOVE) begin
                    n_phase = PH_RR_CHK;
                end else if (move_done && r_phase == PH_RR_MOVE) begin
                    if (i_cfg.trip_total == 8'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_trip_count = 8'd1;
                        n_direction  = 1'b1;
                        n_step_count = '0;
                        n_phase      = PH_SEEK_CHK;
                    end
                end else if (move_done) begin
                    n_tick_timer = r_direction
                        ? tload({12'd0, i_cfg.pause_after_left_ticks})
                        : tload({12'd0, i_cfg.pause_after_right_ticks});
                    n_phase = PH_PAUSE;
                end else if (pulse_idle) begin
                    n_step_count  = r_step_count - C_ONE;
                    n_pulse_level = 1'b1;
                    n_tick_timer  = half_load;
                end else begin
                    n_pulse_level = adv_pulse;
                    n_tick_timer  = adv_timer;
                end
            end
            PH_RR_CHK, PH_RR_DEB: begin
                if (r_phase == PH_RR_CHK && right_low) begin
                    n_tick_timer = deb_load;
                    n_phase      = PH_RR_DEB;
                end else if (r_phase == PH_RR_DEB && r_tick_timer != '0) begin
                    n_tick_timer = r_tick_timer - T_ONE;
                end else if (r_phase == PH_RR_DEB && right_low) begin
                    n_direction  = 1'b0;
                    n_step_count = backoff_x5;
                    n_phase      = PH_RR_MOVE;
                end else if (i_cfg.trip_total == 8'd0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_trip_count = 8'd1;
                    n_direction  = 1'b1;
                    n_step_count = '0;
                    n_phase      = PH_SEEK_CHK;
                end
            end
            PH_SEEK_CHK: begin
                if (r_step_count >= i_cfg.travel_limit) begin
                    n_phase = r_direction ? PH_ERR_R : PH_ERR_L;
                end else if (target_low) begin
                    n_tick_timer = deb_load;
                    n_phase      = PH_SEEK_DEB;
                end else begin
                    n_pulse_level = 1'b1;
                    n_tick_timer  = half_load;
                    n_phase       = PH_SEEK_PULSE;
                end
            end
            PH_SEEK_DEB: begin
                if (r_tick_timer != '0) begin
                    n_tick_timer = r_tick_timer - T_ONE;
                end else if (target_low) begin
                    n_direction  = ~r_direction;
                    n_step_count = {4'd0, i_cfg.retreat_steps};
                    n_phase      = PH_BACKOFF;
                end else begin
                    n_pulse_level = 1'b1;
                    n_tick_timer  = half_load;
                    n_phase       = PH_SEEK_PULSE;
                end
            end
            PH_SEEK_PULSE: begin
                n_pulse_level = adv_pulse;
                n_tick_timer  = adv_timer;
                if (adv_done) begin
                    n_step_count = r_step_count + C_ONE;
                    n_phase      = PH_SEEK_CHK;
                end
            end
            PH_PAUSE: begin
                if (r_tick_timer != '0) begin
                    n_tick_timer = r_tick_timer - T_ONE;
                end else if (!r_direction) begin
                    n_step_count = '0;
                    n_phase      = PH_SEEK_CHK;
                end else if (r_trip_count >= i_cfg.trip_total) begin
                    n_phase = PH_DONE;
                end else begin
                    n_trip_count = r_trip_count + 8'd1;
                    n_direction  = 1'b1;
                    n_step_count = '0;
                    n_phase      = PH_SEEK_CHK;
                end
            end
            default: begin
                if (i_tick.start_req) begin
                    n_trip_count  = '0;
                    n_step_count  = '0;
                    n_tick_timer  = '0;
                    n_pulse_level = 1'b0;
                    n_phase       = PH_RL_CHK;
                end
            end
        endcase
    end

    always_comb begin
        n_result.step_out    = n_pulse_level;
        n_result.dir_out     = n_direction;
        n_result.trip_number = n_trip_count;
        case (n_phase)
            PH_DONE:   n_result.status = ST_DONE;
            PH_ERR_R:  n_result.status = ST_ERR_R;
            PH_ERR_L:  n_result.status = ST_ERR_L;
            PH_IDLE:   n_result.status = ST_IDLE;
            PH_UNUSED: n_result.status = ST_IDLE;
            default:   n_result.status = ST_RUNNING;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_step_count  <= '0;
            r_tick_timer  <= '0;
            r_trip_count  <= '0;
            r_pulse_level <= 1'b0;
            r_direction   <= 1'b0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_step_count  <= n_step_count;
            r_tick_timer  <= n_tick_timer;
            r_trip_count  <= n_trip_count;
            r_pulse_level <= n_pulse_level;
            r_direction   <= n_direction;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
